[design/xfde_pkg.sv]
`timescale 1ns / 1ps

package xfde_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int CODE_WIDTH = 45;
  localparam int LEN_WIDTH = 6;
  localparam int COUNT_WIDTH = 17;
  localparam int ZC_WIDTH = 6;

  localparam logic [LEN_WIDTH-1:0] WINDOW_CLEAR = 6'd32;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = 17'h1FFFF;
  localparam logic [COUNT_WIDTH-1:0] CAPACITY_RESET = 17'd4096;
  localparam logic [COUNT_WIDTH:0] BLOCK_MARGIN = 18'd32;
  localparam logic [LEN_WIDTH-1:0] RAW_LENGTH = 6'd32;
  localparam logic [LEN_WIDTH-1:0] ZERO_LENGTH = 6'd1;
  localparam logic [LEN_WIDTH-1:0] WIN_HDR_LENGTH = 6'd2;
  localparam logic [LEN_WIDTH-1:0] NEW_HDR_LENGTH = 6'd13;
  localparam logic [1:0] WIN_PREFIX = 2'b10;
  localparam logic [1:0] NEW_PREFIX = 2'b11;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] prev;
    logic [LEN_WIDTH-1:0]   win_lead;
    logic [LEN_WIDTH-1:0]   win_trail;
    logic [LEN_WIDTH-1:0]   win_len;
    logic [COUNT_WIDTH-1:0] count;
  } enc_state_t;

  typedef struct packed {
    logic [CODE_WIDTH-1:0] code;
    logic [LEN_WIDTH-1:0]  code_length;
    logic                  new_block;
    logic                  block_full;
  } enc_result_t;

  // index of the single set bit of a one-hot word
  function automatic logic [ZC_WIDTH-1:0] onehot_index(input logic [VALUE_WIDTH-1:0] oh);
    logic [ZC_WIDTH-1:0] idx;
    idx = '0;
    for (int i = 0; i < VALUE_WIDTH; i++) begin
      if (oh[i]) begin
        idx = idx | ZC_WIDTH'(i);
      end
    end
    return idx;
  endfunction

  // trailing zeros of a nonzero word
  function automatic logic [ZC_WIDTH-1:0] ctz(input logic [VALUE_WIDTH-1:0] v);
    logic [VALUE_WIDTH-1:0] low;
    low = v & (~v + VALUE_WIDTH'(1));
    return onehot_index(low);
  endfunction

  // leading zeros of a nonzero word
  function automatic logic [ZC_WIDTH-1:0] clz(input logic [VALUE_WIDTH-1:0] v);
    logic [VALUE_WIDTH-1:0] rev;
    for (int i = 0; i < VALUE_WIDTH; i++) begin
      rev[i] = v[VALUE_WIDTH-1-i];
    end
    return ctz(rev);
  endfunction

endpackage

[design/xfde_encode.sv]
`timescale 1ns / 1ps

module xfde_encode (
  input  logic [xfde_pkg::VALUE_WIDTH-1:0] sample,
  input  logic [xfde_pkg::COUNT_WIDTH-1:0] capacity,
  input  xfde_pkg::enc_state_t             st,
  output xfde_pkg::enc_state_t             st_next,
  output xfde_pkg::enc_result_t            result
);

  xfde_pkg::enc_state_t             s0;
  logic                             roll;
  logic                             reuse;
  logic [xfde_pkg::VALUE_WIDTH-1:0] x;
  logic [xfde_pkg::ZC_WIDTH-1:0]    tz;
  logic [xfde_pkg::ZC_WIDTH-1:0]    lz;
  logic [xfde_pkg::LEN_WIDTH-1:0]   ml;
  logic [xfde_pkg::VALUE_WIDTH-1:0] x_win;
  logic [xfde_pkg::VALUE_WIDTH:0]   win_mask;
  logic [xfde_pkg::VALUE_WIDTH-1:0] x_new;
  logic [12:0]                      new_hdr;
  logic [xfde_pkg::CODE_WIDTH-1:0]  code_win;
  logic [xfde_pkg::CODE_WIDTH-1:0]  code_new;
  logic [xfde_pkg::LEN_WIDTH-1:0]   len;
  logic [xfde_pkg::COUNT_WIDTH:0]   count_sum;

  always_comb begin
    roll = ({1'b0, st.count} + xfde_pkg::BLOCK_MARGIN) >= {1'b0, capacity};
    s0 = st;
    if (roll) begin
      s0.count = '0;
      s0.prev = '0;
      s0.win_lead = xfde_pkg::WINDOW_CLEAR;
      s0.win_trail = xfde_pkg::WINDOW_CLEAR;
      s0.win_len = xfde_pkg::WINDOW_CLEAR;
    end

    x = s0.prev ^ sample;
    tz = xfde_pkg::ctz(x);
    lz = xfde_pkg::clz(x);
    ml = xfde_pkg::RAW_LENGTH - lz - tz;
    reuse = (s0.win_lead <= lz) && (s0.win_trail <= tz);

    // bits inside the stored window
    x_win = x >> s0.win_trail[4:0];
    win_mask = ((xfde_pkg::VALUE_WIDTH+1)'(1) << s0.win_len) - (xfde_pkg::VALUE_WIDTH+1)'(1);
    code_win = ({43'd0, xfde_pkg::WIN_PREFIX} << s0.win_len)
             | {13'd0, x_win & win_mask[xfde_pkg::VALUE_WIDTH-1:0]};

    // new window form
    x_new = x >> tz[4:0];
    new_hdr = {xfde_pkg::NEW_PREFIX, lz[4:0], ml};
    code_new = ({32'd0, new_hdr} << ml) | {13'd0, x_new};

    st_next = s0;
    result.new_block = 1'b0;
    if (s0.count == '0) begin
      result.code = {13'd0, sample};
      len = xfde_pkg::RAW_LENGTH;
      result.new_block = 1'b1;
      st_next.prev = sample;
    end else if (x == '0) begin
      result.code = '0;
      len = xfde_pkg::ZERO_LENGTH;
    end else if (reuse) begin
      result.code = code_win;
      len = xfde_pkg::WIN_HDR_LENGTH + s0.win_len;
      st_next.prev = sample;
    end else begin
      result.code = code_new;
      len = xfde_pkg::NEW_HDR_LENGTH + ml;
      st_next.prev = sample;
      st_next.win_lead = lz;
      st_next.win_trail = tz;
      st_next.win_len = ml;
    end

    count_sum = {1'b0, s0.count} + {12'd0, len};
    st_next.count = count_sum[xfde_pkg::COUNT_WIDTH] ? xfde_pkg::COUNT_MAX
                  : count_sum[xfde_pkg::COUNT_WIDTH-1:0];
    result.code_length = len;
    result.block_full = st_next.count >= capacity;
  end

endmodule

[design/xor_float_delta_encoder.sv]
`timescale 1ns / 1ps

// XOR float delta encoder: one variable-length code word per 32-bit sample.
// input channel: in_valid/in_ready with sample, one transfer per cycle max.
// output channel: out_valid/out_ready with code, code_length, new_block and
//   block_full; code is right aligned, first written bit most significant.
// config channel: cfg_valid/cfg_ready with cfg_data, the block bit capacity;
//   always ready; the user keeps it written only while the encoder is idle,
//   the encoder does no check. A transferred sample lands in the input
//   register, and its code word then lands in the output register.
// throughput: one sample per cycle while out_ready is high; the encoder
//   state (previous sample, window, block bit count) feeds back through it.
// stall: when out_ready is low the output register holds, the input register
//   fills, and in_ready drops until the output transfer happens.
// reset: capacity returns to 4096, previous sample to 0, window to 32/32/32,
//   block bit count to 0, both pipeline registers empty.
module xor_float_delta_encoder (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [xfde_pkg::COUNT_WIDTH-1:0] cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [xfde_pkg::VALUE_WIDTH-1:0] sample,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [xfde_pkg::CODE_WIDTH-1:0]  code,
  output logic [xfde_pkg::LEN_WIDTH-1:0]   code_length,
  output logic                             new_block,
  output logic                             block_full
);

  logic [xfde_pkg::COUNT_WIDTH-1:0] capacity;
  xfde_pkg::enc_state_t             st;
  xfde_pkg::enc_state_t             st_next;
  xfde_pkg::enc_result_t            result;
  xfde_pkg::enc_result_t            out_reg;
  logic                             s1_valid;
  logic [xfde_pkg::VALUE_WIDTH-1:0] s1_sample;
  logic                             advance;

  assign cfg_ready = 1'b1;
  assign advance = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  xfde_encode u_encode (
    .sample   (s1_sample),
    .capacity (capacity),
    .st       (st),
    .st_next  (st_next),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= xfde_pkg::CAPACITY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.prev <= '0;
      st.win_lead <= xfde_pkg::WINDOW_CLEAR;
      st.win_trail <= xfde_pkg::WINDOW_CLEAR;
      st.win_len <= xfde_pkg::WINDOW_CLEAR;
      st.count <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_sample <= sample;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_reg <= result;
    end
  end

  assign code = out_reg.code;
  assign code_length = out_reg.code_length;
  assign new_block = out_reg.new_block;
  assign block_full = out_reg.block_full;

endmodule

[design/xfde_checker.sv]
`timescale 1ns / 1ps

module xfde_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [xfde_pkg::CODE_WIDTH-1:0]  code,
  input logic [xfde_pkg::LEN_WIDTH-1:0]   code_length,
  input logic                             new_block
);

  // stalled output transfer holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(code) && $stable(code_length))
    else $error("output changed while stalled");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> code_length >= 6'd1 && code_length <= 6'd45)
    else $error("code length out of range");

  a_raw_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && new_block |-> code_length == xfde_pkg::RAW_LENGTH)
    else $error("block start word not raw");

  a_zero_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && code_length == xfde_pkg::ZERO_LENGTH |-> code == '0 && !new_block)
    else $error("one bit word not zero");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid after reset");

endmodule

bind xor_float_delta_encoder xfde_checker u_xfde_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .code        (code),
  .code_length (code_length),
  .new_block   (new_block)
);
